// ===== sv/hkf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkf_pkg: shared types, constants and microprogram of the heading filter
// Operation codes, register-file addresses, sequencer states and the
// microcode table that the sequencer walks for each mode.
// ----------------------------------------------------------------------------
package hkf_pkg;

  // Width of the internal datapath: holds exact heading sums before wrapping
  localparam int unsigned HKF_W = 37;

  localparam logic signed [HKF_W-1:0] S32_MAX = 37'sh00_7FFF_FFFF;
  localparam logic signed [HKF_W-1:0] S32_MIN = 37'sh1F_8000_0000;

  // Item modes
  localparam logic [1:0] MODE_PREDICT = 2'd0;
  localparam logic [1:0] MODE_HUPD    = 2'd1;
  localparam logic [1:0] MODE_HRUPD   = 2'd2;
  localparam logic [1:0] MODE_REINIT  = 2'd3;

  // Operand / destination addresses: flops below 16, scratch memory above
  localparam logic [4:0] RA_H    = 5'd0;
  localparam logic [4:0] RA_R    = 5'd1;
  localparam logic [4:0] RA_P00  = 5'd2;
  localparam logic [4:0] RA_P01  = 5'd3;
  localparam logic [4:0] RA_P10  = 5'd4;
  localparam logic [4:0] RA_P11  = 5'd5;
  localparam logic [4:0] RA_DT   = 5'd6;
  localparam logic [4:0] RA_ZH   = 5'd7;
  localparam logic [4:0] RA_ZR   = 5'd8;
  localparam logic [4:0] RA_H0   = 5'd9;
  localparam logic [4:0] RA_QH   = 5'd10;
  localparam logic [4:0] RA_QR   = 5'd11;
  localparam logic [4:0] RA_RH   = 5'd12;
  localparam logic [4:0] RA_RV   = 5'd13;
  localparam logic [4:0] RA_ONE  = 5'd14;
  localparam logic [4:0] RA_ZERO = 5'd15;
  localparam logic [4:0] RA_T0   = 5'd16;
  localparam logic [4:0] RA_T1   = 5'd17;
  localparam logic [4:0] RA_T2   = 5'd18;
  localparam logic [4:0] RA_T3   = 5'd19;
  localparam logic [4:0] RA_T4   = 5'd20;
  localparam logic [4:0] RA_T5   = 5'd21;
  localparam logic [4:0] RA_T6   = 5'd22;
  localparam logic [4:0] RA_T7   = 5'd23;
  localparam logic [4:0] RA_T8   = 5'd24;
  localparam logic [4:0] RA_T9   = 5'd25;
  localparam logic [4:0] RA_T10  = 5'd26;
  localparam logic [4:0] RA_T11  = 5'd27;
  localparam logic [4:0] RA_T12  = 5'd28;
  localparam logic [4:0] RA_T13  = 5'd29;
  localparam logic [4:0] RA_T14  = 5'd30;
  localparam logic [4:0] RA_T15  = 5'd31;

  // Program entry points
  localparam logic [6:0] PC_PREDICT = 7'd0;
  localparam logic [6:0] PC_HUPD    = 7'd15;
  localparam logic [6:0] PC_HRUPD   = 7'd34;
  localparam logic [6:0] PC_REINIT  = 7'd87;

  typedef enum logic [3:0] {
    OP_ADD,   // saturating add
    OP_SUB,   // saturating subtract
    OP_ADDW,  // exact add
    OP_SUBW,  // exact subtract
    OP_MUL,
    OP_DIV,
    OP_WRAP,
    OP_BRZ,   // zero divisor check
    OP_END
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_WAIT,
    ST_SQRT,
    ST_DONE
  } fsm_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] dst;
    logic [4:0] sa;
    logic [4:0] sb;
  } instr_t;

  function automatic logic signed [HKF_W-1:0] sat32(input logic signed [HKF_W-1:0] x);
    logic signed [HKF_W-1:0] r;
    if (x > S32_MAX) r = S32_MAX;
    else if (x < S32_MIN) r = S32_MIN;
    else r = x;
    return r;
  endfunction

  // pi rounded to frac fraction bits
  function automatic logic signed [HKF_W-1:0] fx_pi(input int unsigned frac);
    logic [63:0] pq;
    logic [63:0] v;
    pq = 64'h3243_F6A8_885A_308D;
    v  = (pq + (64'd1 << (59 - frac))) >> (60 - frac);
    return $signed(v[HKF_W-1:0]);
  endfunction

  function automatic instr_t mk(input op_e op, input logic [4:0] d,
                                input logic [4:0] a, input logic [4:0] b);
    instr_t i;
    i.op  = op;
    i.dst = d;
    i.sa  = a;
    i.sb  = b;
    return i;
  endfunction

  // Microcode table
  function automatic instr_t prog_rom(input logic [6:0] pc);
    instr_t i;
    case (pc)
      // predict
      7'd0:  i = mk(OP_MUL,  RA_T0,  RA_DT,  RA_P10);
      7'd1:  i = mk(OP_ADD,  RA_T1,  RA_P00, RA_T0);
      7'd2:  i = mk(OP_MUL,  RA_T2,  RA_DT,  RA_P11);
      7'd3:  i = mk(OP_ADD,  RA_T3,  RA_P01, RA_T2);
      7'd4:  i = mk(OP_MUL,  RA_T4,  RA_R,   RA_DT);
      7'd5:  i = mk(OP_ADDW, RA_T5,  RA_H,   RA_T4);
      7'd6:  i = mk(OP_WRAP, RA_H,   RA_T5,  RA_ZERO);
      7'd7:  i = mk(OP_MUL,  RA_T6,  RA_T3,  RA_DT);
      7'd8:  i = mk(OP_ADD,  RA_T7,  RA_T1,  RA_T6);
      7'd9:  i = mk(OP_ADD,  RA_P00, RA_T7,  RA_QH);
      7'd10: i = mk(OP_ADD,  RA_P01, RA_T3,  RA_ZERO);
      7'd11: i = mk(OP_MUL,  RA_T8,  RA_P11, RA_DT);
      7'd12: i = mk(OP_ADD,  RA_P10, RA_P10, RA_T8);
      7'd13: i = mk(OP_ADD,  RA_P11, RA_P11, RA_QR);
      7'd14: i = mk(OP_END,  RA_ZERO, RA_ZERO, RA_ZERO);
      // heading-only update
      7'd15: i = mk(OP_SUBW, RA_T0,  RA_ZH,  RA_H);
      7'd16: i = mk(OP_WRAP, RA_T0,  RA_T0,  RA_ZERO);
      7'd17: i = mk(OP_ADD,  RA_T1,  RA_P00, RA_RH);
      7'd18: i = mk(OP_BRZ,  RA_ZERO, RA_T1, RA_ZERO);
      7'd19: i = mk(OP_DIV,  RA_T2,  RA_P00, RA_T1);
      7'd20: i = mk(OP_DIV,  RA_T3,  RA_P10, RA_T1);
      7'd21: i = mk(OP_SUB,  RA_T4,  RA_ONE, RA_T2);
      7'd22: i = mk(OP_MUL,  RA_T5,  RA_T2,  RA_T0);
      7'd23: i = mk(OP_ADDW, RA_T5,  RA_H,   RA_T5);
      7'd24: i = mk(OP_WRAP, RA_H,   RA_T5,  RA_ZERO);
      7'd25: i = mk(OP_MUL,  RA_T6,  RA_T3,  RA_T0);
      7'd26: i = mk(OP_ADD,  RA_R,   RA_R,   RA_T6);
      7'd27: i = mk(OP_MUL,  RA_T7,  RA_T3,  RA_P00);
      7'd28: i = mk(OP_MUL,  RA_T8,  RA_T3,  RA_P01);
      7'd29: i = mk(OP_MUL,  RA_P00, RA_T4,  RA_P00);
      7'd30: i = mk(OP_MUL,  RA_P01, RA_T4,  RA_P01);
      7'd31: i = mk(OP_SUB,  RA_P10, RA_P10, RA_T7);
      7'd32: i = mk(OP_SUB,  RA_P11, RA_P11, RA_T8);
      7'd33: i = mk(OP_END,  RA_ZERO, RA_ZERO, RA_ZERO);
      // heading and rate update
      7'd34: i = mk(OP_SUBW, RA_T0,  RA_ZH,  RA_H);
      7'd35: i = mk(OP_WRAP, RA_T0,  RA_T0,  RA_ZERO);
      7'd36: i = mk(OP_SUB,  RA_T1,  RA_ZR,  RA_R);
      7'd37: i = mk(OP_ADD,  RA_T2,  RA_P00, RA_RH);
      7'd38: i = mk(OP_ADD,  RA_T3,  RA_P11, RA_RV);
      7'd39: i = mk(OP_MUL,  RA_T4,  RA_T2,  RA_T3);
      7'd40: i = mk(OP_MUL,  RA_T5,  RA_P01, RA_P10);
      7'd41: i = mk(OP_SUB,  RA_T4,  RA_T4,  RA_T5);
      7'd42: i = mk(OP_BRZ,  RA_ZERO, RA_T4, RA_ZERO);
      7'd43: i = mk(OP_MUL,  RA_T5,  RA_P00, RA_T3);
      7'd44: i = mk(OP_MUL,  RA_T6,  RA_P01, RA_P10);
      7'd45: i = mk(OP_SUB,  RA_T5,  RA_T5,  RA_T6);
      7'd46: i = mk(OP_DIV,  RA_T5,  RA_T5,  RA_T4);
      7'd47: i = mk(OP_MUL,  RA_T6,  RA_P01, RA_T2);
      7'd48: i = mk(OP_MUL,  RA_T7,  RA_P00, RA_P01);
      7'd49: i = mk(OP_SUB,  RA_T6,  RA_T6,  RA_T7);
      7'd50: i = mk(OP_DIV,  RA_T6,  RA_T6,  RA_T4);
      7'd51: i = mk(OP_MUL,  RA_T7,  RA_P10, RA_T3);
      7'd52: i = mk(OP_MUL,  RA_T8,  RA_P11, RA_P10);
      7'd53: i = mk(OP_SUB,  RA_T7,  RA_T7,  RA_T8);
      7'd54: i = mk(OP_DIV,  RA_T7,  RA_T7,  RA_T4);
      7'd55: i = mk(OP_MUL,  RA_T8,  RA_P11, RA_T2);
      7'd56: i = mk(OP_MUL,  RA_T9,  RA_P10, RA_P01);
      7'd57: i = mk(OP_SUB,  RA_T8,  RA_T8,  RA_T9);
      7'd58: i = mk(OP_DIV,  RA_T8,  RA_T8,  RA_T4);
      7'd59: i = mk(OP_SUB,  RA_T9,  RA_ONE, RA_T5);
      7'd60: i = mk(OP_SUB,  RA_T10, RA_ONE, RA_T8);
      7'd61: i = mk(OP_MUL,  RA_T11, RA_T5,  RA_T0);
      7'd62: i = mk(OP_ADDW, RA_T11, RA_H,   RA_T11);
      7'd63: i = mk(OP_MUL,  RA_T12, RA_T6,  RA_T1);
      7'd64: i = mk(OP_ADDW, RA_T11, RA_T11, RA_T12);
      7'd65: i = mk(OP_WRAP, RA_H,   RA_T11, RA_ZERO);
      7'd66: i = mk(OP_MUL,  RA_T11, RA_T7,  RA_T0);
      7'd67: i = mk(OP_ADDW, RA_T11, RA_R,   RA_T11);
      7'd68: i = mk(OP_MUL,  RA_T12, RA_T8,  RA_T1);
      7'd69: i = mk(OP_ADDW, RA_T11, RA_T11, RA_T12);
      7'd70: i = mk(OP_ADD,  RA_R,   RA_T11, RA_ZERO);
      7'd71: i = mk(OP_MUL,  RA_T11, RA_T9,  RA_P00);
      7'd72: i = mk(OP_MUL,  RA_T12, RA_T6,  RA_P10);
      7'd73: i = mk(OP_SUB,  RA_T11, RA_T11, RA_T12);
      7'd74: i = mk(OP_MUL,  RA_T12, RA_T9,  RA_P01);
      7'd75: i = mk(OP_MUL,  RA_T13, RA_T6,  RA_P11);
      7'd76: i = mk(OP_SUB,  RA_T12, RA_T12, RA_T13);
      7'd77: i = mk(OP_MUL,  RA_T13, RA_T10, RA_P10);
      7'd78: i = mk(OP_MUL,  RA_T14, RA_T7,  RA_P00);
      7'd79: i = mk(OP_SUB,  RA_T13, RA_T13, RA_T14);
      7'd80: i = mk(OP_MUL,  RA_T14, RA_T10, RA_P11);
      7'd81: i = mk(OP_MUL,  RA_T15, RA_T7,  RA_P01);
      7'd82: i = mk(OP_SUB,  RA_P11, RA_T14, RA_T15);
      7'd83: i = mk(OP_ADD,  RA_P00, RA_T11, RA_ZERO);
      7'd84: i = mk(OP_ADD,  RA_P01, RA_T12, RA_ZERO);
      7'd85: i = mk(OP_ADD,  RA_P10, RA_T13, RA_ZERO);
      7'd86: i = mk(OP_END,  RA_ZERO, RA_ZERO, RA_ZERO);
      // reinitialize
      7'd87: i = mk(OP_WRAP, RA_H,   RA_H0,  RA_ZERO);
      7'd88: i = mk(OP_ADD,  RA_R,   RA_ZERO, RA_ZERO);
      7'd89: i = mk(OP_ADD,  RA_P00, RA_ONE, RA_ZERO);
      7'd90: i = mk(OP_ADD,  RA_P01, RA_ZERO, RA_ZERO);
      7'd91: i = mk(OP_ADD,  RA_P10, RA_ZERO, RA_ZERO);
      7'd92: i = mk(OP_ADD,  RA_P11, RA_ONE, RA_ZERO);
      default: i = mk(OP_END, RA_ZERO, RA_ZERO, RA_ZERO);
    endcase
    return i;
  endfunction

endpackage

// ===== sv/heading_kalman_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_kalman_filter: two-state heading / rate Kalman filter
// Microcoded sequencer driving shared multiply, divide, wrap and root units.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item with a mode:
//   predict, heading-only update, heading and rate update, or reinitialize.
//   Output channel (out_valid_o / out_stall_i) returns one item per input:
//   heading, rate, sqrt of heading variance and the singular flag.
//   Config writes (cfg_we_i, cfg_addr_i, cfg_wdata_i) take effect at once;
//   write only while the block is idle.
// Sequencing:
//   Each microinstruction passes through a fetch and an execute state;
//   multiply, divide and wrap then wait in a wait state for their unit.
//   When the program ends, or a zero divisor stops it, the root unit takes
//   the square root of the heading variance. One item is worked on at a
//   time; in_stall_o is high while it runs.
// Reset: estimates clear, covariance is identity, noise registers load
//   their defaults. A stalled result holds; the next item may be accepted
//   meanwhile and finishes once the held result has been taken.
// ----------------------------------------------------------------------------
module heading_kalman_filter
  import hkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [30:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         mode_i,
  input  logic [24:0]        time_step_i,
  input  logic signed [31:0] measured_heading_i,
  input  logic signed [31:0] measured_rate_i,
  input  logic signed [26:0] initial_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [26:0] heading_now_o,
  output logic signed [31:0] rate_now_o,
  output logic [30:0]        heading_uncertainty_o,
  output logic               singular_o
);

  localparam logic signed [HKF_W-1:0] FX_ONE = 37'sd1 <<< FRAC_BITS;
  localparam logic signed [HKF_W-1:0] FX_PI  = fx_pi(FRAC_BITS);
  localparam logic [1:0] CFG_QH = 2'd0;
  localparam logic [1:0] CFG_QR = 2'd1;
  localparam logic [1:0] CFG_RH = 2'd2;
  localparam logic [1:0] CFG_RV = 2'd3;

  fsm_e state_q, state_d;
  logic [6:0] pc_q, pc_d;
  instr_t instr;

  logic signed [31:0] h_q, r_q, p00_q, p01_q, p10_q, p11_q;
  logic [30:0] qh_q, qr_q, rh_q, rv_q;
  logic [1:0]  mode_q;
  logic [24:0] dt_q;
  logic signed [31:0] zh_q, zr_q;
  logic signed [26:0] h0_q;
  logic singular_q;

  logic signed [HKF_W-1:0] tmp_mem [16];
  logic signed [HKF_W-1:0] tmpa_q, tmpb_q, flopa_q, flopb_q;
  logic sela_q, selb_q;
  logic signed [HKF_W-1:0] opa, opb, alu_res, wb_data;

  logic accept, is_alu, wb_en, brz_hit, unit_done, load_out;
  logic mul_start, div_start, wrap_start, sqrt_start;
  logic signed [31:0] mul_res, div_res;
  logic signed [HKF_W-1:0] wrap_res;
  logic mul_done, div_done, wrap_done, sqrt_done;
  logic [30:0] sqrt_res;

  logic out_valid_q;
  logic signed [26:0] heading_out_q;
  logic signed [31:0] rate_out_q;
  logic [30:0] unc_out_q;
  logic singular_out_q;

  function automatic logic signed [HKF_W-1:0] sx32(input logic signed [31:0] v);
    return {{(HKF_W-32){v[31]}}, v};
  endfunction

  // flop-sourced operand value
  function automatic logic signed [HKF_W-1:0] flop_src(input logic [4:0] s);
    logic signed [HKF_W-1:0] v;
    unique case (s)
      RA_H:    v = sx32(h_q);
      RA_R:    v = sx32(r_q);
      RA_P00:  v = sx32(p00_q);
      RA_P01:  v = sx32(p01_q);
      RA_P10:  v = sx32(p10_q);
      RA_P11:  v = sx32(p11_q);
      RA_DT:   v = {{(HKF_W-25){1'b0}}, dt_q};
      RA_ZH:   v = sx32(zh_q);
      RA_ZR:   v = sx32(zr_q);
      RA_H0:   v = {{(HKF_W-27){h0_q[26]}}, h0_q};
      RA_QH:   v = {{(HKF_W-31){1'b0}}, qh_q};
      RA_QR:   v = {{(HKF_W-31){1'b0}}, qr_q};
      RA_RH:   v = {{(HKF_W-31){1'b0}}, rh_q};
      RA_RV:   v = {{(HKF_W-31){1'b0}}, rv_q};
      RA_ONE:  v = FX_ONE;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign instr  = prog_rom(pc_q);
  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign opa    = sela_q ? tmpa_q : flopa_q;
  assign opb    = selb_q ? tmpb_q : flopb_q;

  // next state and program counter
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_FETCH;
          unique case (mode_i)
            MODE_PREDICT: pc_d = PC_PREDICT;
            MODE_HUPD:    pc_d = PC_HUPD;
            MODE_HRUPD:   pc_d = PC_HRUPD;
            default:      pc_d = PC_REINIT;
          endcase
        end
      end
      ST_FETCH: state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (instr.op)
          OP_MUL, OP_DIV, OP_WRAP: state_d = ST_WAIT;
          OP_END: state_d = ST_SQRT;
          OP_BRZ: begin
            if (opa == '0) begin
              state_d = ST_SQRT;
            end else begin
              state_d = ST_FETCH;
              pc_d    = pc_q + 7'd1;
            end
          end
          default: begin
            state_d = ST_FETCH;
            pc_d    = pc_q + 7'd1;
          end
        endcase
      end
      ST_WAIT: begin
        if (unit_done) begin
          state_d = ST_FETCH;
          pc_d    = pc_q + 7'd1;
        end
      end
      ST_SQRT: if (sqrt_done) state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    is_alu     = (instr.op == OP_ADD) || (instr.op == OP_SUB) ||
                 (instr.op == OP_ADDW) || (instr.op == OP_SUBW);
    mul_start  = (state_q == ST_EXEC) && (instr.op == OP_MUL);
    div_start  = (state_q == ST_EXEC) && (instr.op == OP_DIV);
    wrap_start = (state_q == ST_EXEC) && (instr.op == OP_WRAP);
    brz_hit    = (state_q == ST_EXEC) && (instr.op == OP_BRZ) && (opa == '0);
    sqrt_start = (state_q == ST_EXEC) && ((instr.op == OP_END) || brz_hit);
    unit_done  = mul_done || div_done || wrap_done;
    wb_en      = ((state_q == ST_EXEC) && is_alu) || ((state_q == ST_WAIT) && unit_done);
    load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  end

  // add / subtract
  always_comb begin
    case (instr.op)
      OP_ADD:  alu_res = sat32(opa + opb);
      OP_SUB:  alu_res = sat32(opa - opb);
      OP_SUBW: alu_res = opa - opb;
      default: alu_res = opa + opb;
    endcase
  end

  // writeback source
  always_comb begin
    if (state_q == ST_EXEC) wb_data = alu_res;
    else if (instr.op == OP_MUL) wb_data = sx32(mul_res);
    else if (instr.op == OP_DIV) wb_data = sx32(div_res);
    else wb_data = wrap_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pc_q    <= PC_PREDICT;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
    end
  end

  // filter state and noise registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q   <= '0;
      r_q   <= '0;
      p00_q <= 32'(FX_ONE);
      p01_q <= '0;
      p10_q <= '0;
      p11_q <= 32'(FX_ONE);
      qh_q  <= 31'd167772;
      qr_q  <= 31'd1677722;
      rh_q  <= 31'd1677722;
      rv_q  <= 31'd3355443;
      singular_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          CFG_QH:  qh_q <= cfg_wdata_i;
          CFG_QR:  qr_q <= cfg_wdata_i;
          CFG_RH:  rh_q <= cfg_wdata_i;
          default: rv_q <= cfg_wdata_i;
        endcase
      end
      if (wb_en) begin
        case (instr.dst)
          RA_H:    h_q   <= wb_data[31:0];
          RA_R:    r_q   <= wb_data[31:0];
          RA_P00:  p00_q <= wb_data[31:0];
          RA_P01:  p01_q <= wb_data[31:0];
          RA_P10:  p10_q <= wb_data[31:0];
          RA_P11:  p11_q <= wb_data[31:0];
          default: ;
        endcase
      end
      if (accept) singular_q <= 1'b0;
      else if (brz_hit) singular_q <= 1'b1;
    end
  end

  // item capture, operand fetch and scratch memory
  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= mode_i;
      dt_q   <= time_step_i;
      zh_q   <= measured_heading_i;
      zr_q   <= measured_rate_i;
      h0_q   <= initial_heading_i;
    end
    if (state_q == ST_FETCH) begin
      flopa_q <= flop_src(instr.sa);
      flopb_q <= flop_src(instr.sb);
      tmpa_q  <= tmp_mem[instr.sa[3:0]];
      tmpb_q  <= tmp_mem[instr.sb[3:0]];
      sela_q  <= instr.sa[4];
      selb_q  <= instr.sb[4];
    end
    if (wb_en && instr.dst[4]) tmp_mem[instr.dst[3:0]] <= wb_data;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      heading_out_q  <= h_q[26:0];
      rate_out_q     <= r_q;
      unc_out_q      <= sqrt_res;
      singular_out_q <= singular_q;
    end
  end

  hkf_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (opa[31:0]),
    .b_i     (opb[31:0]),
    .res_o   (mul_res),
    .done_o  (mul_done)
  );

  hkf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .a_i     (opa[31:0]),
    .b_i     (opb[31:0]),
    .res_o   (div_res),
    .done_o  (div_done)
  );

  hkf_wrap #(.FRAC_BITS(FRAC_BITS)) u_wrap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (wrap_start),
    .x_i     (opa),
    .res_o   (wrap_res),
    .done_o  (wrap_done)
  );

  hkf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .p_i     (p00_q),
    .res_o   (sqrt_res),
    .done_o  (sqrt_done)
  );

  assign in_stall_o            = (state_q != ST_IDLE);
  assign out_valid_o           = out_valid_q;
  assign heading_now_o         = heading_out_q;
  assign rate_now_o            = rate_out_q;
  assign heading_uncertainty_o = unc_out_q;
  assign singular_o            = singular_out_q;

  // accepted item starts its program on the next cycle
  a_accept_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == ST_FETCH)
    else $error("item accepted but sequencer did not start");

  // unit completion only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    unit_done |-> state_q == ST_WAIT)
    else $error("unit done outside wait state");

  // stored heading stays wrapped
  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sx32(h_q) <= FX_PI) && (sx32(h_q) >= -FX_PI))
    else $error("heading estimate outside -pi..pi");

  // only update items can be singular
  a_singular_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    singular_q |-> (mode_q == MODE_HUPD || mode_q == MODE_HRUPD))
    else $error("singular flag on predict or reinitialize");

endmodule

// ===== sv/hkf_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkf_mul: fixed-point multiplier
// Registered product, then round-half-up, arithmetic shift and 32-bit saturation.
// ----------------------------------------------------------------------------
module hkf_mul
  import hkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o,
  output logic               done_o
);

  localparam logic signed [63:0] RND = 64'sd1 <<< (FRAC_BITS - 1);

  logic signed [63:0] prod_q;
  logic               vld_q;
  logic               done_q;
  logic signed [31:0] res_q;
  logic signed [63:0] shifted;

  // round and shift the registered product
  always_comb begin
    shifted = (prod_q + RND) >>> FRAC_BITS;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start_i;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) prod_q <= a_i * b_i;
    if (vld_q) begin
      if (shifted > 64'sh0000_0000_7FFF_FFFF) res_q <= 32'sh7FFF_FFFF;
      else if (shifted < -64'sh0000_0000_8000_0000) res_q <= 32'sh8000_0000;
      else res_q <= shifted[31:0];
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== sv/hkf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkf_div: fixed-point divider
// Restoring division of (a << FRAC_BITS) by b, one quotient bit per cycle,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module hkf_div
  import hkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  output logic signed [31:0] res_o,
  output logic               done_o
);

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [NW-1:0] QMAX_POS = {{(NW-32){1'b0}}, 32'h7FFF_FFFF};
  localparam logic [NW-1:0] QMAX_NEG = {{(NW-32){1'b0}}, 32'h8000_0000};

  logic [NW-1:0]      num_q;
  logic [NW-1:0]      quo_q;
  logic [31:0]        rem_q;
  logic [31:0]        den_q;
  logic               neg_q;
  logic [CW-1:0]      cnt_q;
  logic               busy_q;
  logic               fin_q;
  logic               done_q;
  logic signed [31:0] res_q;
  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic [32:0]        trial;
  logic               qbit;
  logic [31:0]        rem_n;

  assign mag_a = a_i[31] ? (32'd0 - a_i) : a_i;
  assign mag_b = b_i[31] ? (32'd0 - b_i) : b_i;

  // one restoring step
  always_comb begin
    trial = {rem_q, num_q[NW-1]};
    qbit  = (trial >= {1'b0, den_q});
    rem_n = qbit ? 32'(trial - {1'b0, den_q}) : trial[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {mag_a, {FRAC_BITS{1'b0}}};
      den_q <= mag_b;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= a_i[31] ^ b_i[31];
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= rem_n;
      quo_q <= {quo_q[NW-2:0], qbit};
    end
    // sign and saturate
    if (fin_q) begin
      if (neg_q) begin
        if (quo_q > QMAX_NEG) res_q <= 32'sh8000_0000;
        else res_q <= 32'd0 - quo_q[31:0];
      end else begin
        if (quo_q > QMAX_POS) res_q <= 32'sh7FFF_FFFF;
        else res_q <= quo_q[31:0];
      end
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== sv/hkf_wrap.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkf_wrap: angle normalizer
// Brings a wide angle into -pi..pi by removing whole turns, one scaled turn
// compare and subtract per cycle; exactly +-pi passes unchanged.
// ----------------------------------------------------------------------------
module hkf_wrap
  import hkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [HKF_W-1:0] x_i,
  output logic signed [HKF_W-1:0] res_o,
  output logic                    done_o
);

  localparam logic signed [HKF_W-1:0] FX_PI  = fx_pi(FRAC_BITS);
  localparam logic signed [HKF_W-1:0] TWO_PI = FX_PI <<< 1;
  localparam int unsigned STEPS = 33 - FRAC_BITS;
  localparam int unsigned CW = $clog2(STEPS + 1);

  logic signed [HKF_W-1:0] y_q;
  logic signed [HKF_W-1:0] term_q;
  logic signed [HKF_W-1:0] res_q;
  logic signed [HKF_W-1:0] y_n;
  logic                    neg_q;
  logic                    busy_q;
  logic                    done_q;
  logic [CW-1:0]           cnt_q;

  // remove the current multiple of a turn if the excess stays positive
  assign y_n = (y_q > term_q) ? (y_q - term_q) : y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(STEPS);
        if (x_i > FX_PI || x_i < -FX_PI) busy_q <= 1'b1;
        else done_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      term_q <= TWO_PI <<< (STEPS - 1);
      neg_q  <= (x_i < -FX_PI);
      res_q  <= x_i;
      if (x_i < -FX_PI) y_q <= -FX_PI - x_i;
      else y_q <= x_i - FX_PI;
    end else if (busy_q) begin
      y_q    <= y_n;
      term_q <= term_q >>> 1;
      if (cnt_q == CW'(1)) res_q <= neg_q ? (FX_PI - y_n) : (y_n - FX_PI);
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== sv/hkf_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hkf_sqrt: fixed-point square root
// Bit-pair integer square root of (p << FRAC_BITS), one result bit per cycle;
// a variance of zero or below yields zero.
// ----------------------------------------------------------------------------
module hkf_sqrt
  import hkf_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] p_i,
  output logic [30:0]        res_o,
  output logic               done_o
);

  logic [63:0] v_q;
  logic [63:0] r_q;
  logic [63:0] bit_q;
  logic        busy_q;
  logic        done_q;
  logic [63:0] trial;

  assign trial = r_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bit_q == 64'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one root bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= (p_i > 32'sd0) ? (64'(p_i) << FRAC_BITS) : 64'd0;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign res_o  = r_q[30:0];
  assign done_o = done_q;

endmodule

// ===== dv/tb_heading_kalman_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_heading_kalman_filter: self-checking bench for the heading Kalman filter
// Drives predict, update and reinitialize items, including the zero-divisor
// paths and extreme fields, through several noise settings. A fixed-point
// filter model in the bench computes each result, and every returned item
// is compared field by field in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_heading_kalman_filter;
  import hkf_pkg::*;

  localparam int unsigned FB = 24;
  localparam longint FXONE = longint'(1) << FB;
  localparam longint FXPI = longint'((64'h3243F6A8885A308D + (64'd1 << (59 - FB))) >> (60 - FB));
  localparam longint I32MAX = 64'sd2147483647;
  localparam longint I32MIN = -64'sd2147483648;

  typedef struct {
    logic [1:0]         mode;
    logic [24:0]        dt;
    logic signed [31:0] zh;
    logic signed [31:0] zr;
    logic signed [26:0] h0;
  } meas_t;

  typedef struct {
    logic [26:0] heading;
    logic [31:0] rate;
    logic [30:0] sigma;
    logic        singular;
  } est_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_addr_i = '0;
  logic [30:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] mode_i = '0;
  logic [24:0] time_step_i = '0;
  logic signed [31:0] measured_heading_i = '0;
  logic signed [31:0] measured_rate_i = '0;
  logic signed [26:0] initial_heading_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [26:0] heading_now_o;
  logic signed [31:0] rate_now_o;
  logic [30:0] heading_uncertainty_o;
  logic singular_o;

  heading_kalman_filter uut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // filter state mirrored by the bench
  longint hd, rt;
  longint cov [4];
  longint noise [4];

  meas_t pend_q [$];
  est_t  est_q [$];
  meas_t offered;
  int    n_sent = 0;
  int    n_got = 0;
  int    errors = 0;

  function automatic longint sat(longint x);
    if (x > I32MAX) return I32MAX;
    if (x < I32MIN) return I32MIN;
    return x;
  endfunction

  function automatic longint fxmul(longint a, longint b);
    return sat((a * b + (longint'(1) << (FB - 1))) >>> FB);
  endfunction

  function automatic longint fxdiv(longint a, longint b);
    return sat((a * FXONE) / b);
  endfunction

  function automatic longint wrap(longint x);
    longint k;
    if (x > FXPI) begin
      k = (x - FXPI + 2 * FXPI - 1) / (2 * FXPI);
      x -= k * 2 * FXPI;
    end else if (x < -FXPI) begin
      k = (-FXPI - x + 2 * FXPI - 1) / (2 * FXPI);
      x += k * 2 * FXPI;
    end
    return x;
  endfunction

  function automatic longint unsigned root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // advance the mirrored filter by one item and return its estimate
  function automatic est_t filter_step(meas_t m);
    longint dt, zh, zr, p00, p01, p10, p11, rh, rv;
    longint t00, t01, yh, yv, s, s00, s11, det, k0, k1, k00, k01, k10, k11, a, b;
    est_t e;
    dt = m.dt;
    zh = m.zh;
    zr = m.zr;
    p00 = cov[0]; p01 = cov[1]; p10 = cov[2]; p11 = cov[3];
    rh = noise[2]; rv = noise[3];
    e.singular = 1'b0;
    case (m.mode)
      MODE_PREDICT: begin
        t00 = sat(p00 + fxmul(dt, p10));
        t01 = sat(p01 + fxmul(dt, p11));
        hd = wrap(hd + fxmul(rt, dt));
        cov[0] = sat(sat(t00 + fxmul(t01, dt)) + noise[0]);
        cov[1] = t01;
        cov[2] = sat(p10 + fxmul(p11, dt));
        cov[3] = sat(p11 + noise[1]);
      end
      MODE_HUPD: begin
        yh = wrap(zh - hd);
        s = sat(p00 + rh);
        if (s == 0) begin
          e.singular = 1'b1;
        end else begin
          k0 = fxdiv(p00, s);
          k1 = fxdiv(p10, s);
          a = sat(FXONE - k0);
          hd = wrap(hd + fxmul(k0, yh));
          rt = sat(rt + fxmul(k1, yh));
          cov[0] = fxmul(a, p00);
          cov[1] = fxmul(a, p01);
          cov[2] = sat(p10 - fxmul(k1, p00));
          cov[3] = sat(p11 - fxmul(k1, p01));
        end
      end
      MODE_HRUPD: begin
        yh = wrap(zh - hd);
        yv = sat(zr - rt);
        s00 = sat(p00 + rh);
        s11 = sat(p11 + rv);
        det = sat(fxmul(s00, s11) - fxmul(p01, p10));
        if (det == 0) begin
          e.singular = 1'b1;
        end else begin
          k00 = fxdiv(sat(fxmul(p00, s11) - fxmul(p01, p10)), det);
          k01 = fxdiv(sat(fxmul(p01, s00) - fxmul(p00, p01)), det);
          k10 = fxdiv(sat(fxmul(p10, s11) - fxmul(p11, p10)), det);
          k11 = fxdiv(sat(fxmul(p11, s00) - fxmul(p10, p01)), det);
          a = sat(FXONE - k00);
          b = sat(FXONE - k11);
          hd = wrap(hd + fxmul(k00, yh) + fxmul(k01, yv));
          rt = sat(rt + fxmul(k10, yh) + fxmul(k11, yv));
          cov[0] = sat(fxmul(a, p00) - fxmul(k01, p10));
          cov[1] = sat(fxmul(a, p01) - fxmul(k01, p11));
          cov[2] = sat(fxmul(b, p10) - fxmul(k10, p00));
          cov[3] = sat(fxmul(b, p11) - fxmul(k10, p01));
        end
      end
      default: begin
        hd = wrap(longint'(m.h0));
        rt = 0;
        cov = '{FXONE, 0, 0, FXONE};
      end
    endcase
    e.heading = hd[26:0];
    e.rate = rt[31:0];
    e.sigma = (cov[0] > 0) ? root(longint'(cov[0]) << FB) : '0;
    return e;
  endfunction

  function automatic meas_t mk_meas(logic [1:0] md, logic [24:0] dt, logic [31:0] zh,
                                    logic [31:0] zr, logic [26:0] h0);
    meas_t m;
    m.mode = md; m.dt = dt; m.zh = zh; m.zr = zr; m.h0 = h0;
    return m;
  endfunction

  // random item: mostly plausible tracking, some wild fields
  function automatic meas_t rand_meas();
    meas_t m;
    int r;
    r = $urandom_range(99);
    m.mode = (r < 40) ? MODE_PREDICT : (r < 65) ? MODE_HUPD : (r < 92) ? MODE_HRUPD : MODE_REINIT;
    m.dt = ($urandom_range(9) == 0) ? 25'($urandom) : 25'($urandom_range(0, 1 << 22));
    m.zh = ($urandom_range(5) == 0) ? 32'($urandom)
         : 32'(hd + $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23));
    m.zr = ($urandom_range(5) == 0) ? 32'($urandom)
         : 32'(rt + $signed(32'($urandom_range(0, 1 << 24))) - (1 << 23));
    m.h0 = ($urandom_range(3) == 0) ? 27'($urandom)
         : 27'($signed(32'($urandom_range(0, 105414358))) - 52707179);
    return m;
  endfunction

  // sender: offers queued items, idles at random except in a calm stretch
  always @(posedge clk_i) begin
    est_t e;
    logic fire;
    if (rst_ni) begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        e = filter_step(offered);
        est_q.push_back(e);
        n_sent++;
      end
      if (!in_valid_i || fire) begin
        if (pend_q.size() != 0 &&
            !((n_sent < 400 || n_sent >= 520) && $urandom_range(99) < 35)) begin
          offered = pend_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= offered.mode;
          time_step_i <= offered.dt;
          measured_heading_i <= offered.zh;
          measured_rate_i <= offered.zr;
          initial_heading_i <= offered.h0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: checks results, stalls at random and once for a long stretch
  int hold_cnt = 0;
  always @(posedge clk_i) begin
    est_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (est_q.size() == 0) begin
          $display("%0t: unexpected item heading %h", $time, heading_now_o);
          errors++;
        end else begin
          e = est_q.pop_front();
          if (heading_now_o !== e.heading) begin
            $display("%0t: heading exp %h got %h", $time, e.heading, heading_now_o);
            errors++;
          end
          if (rate_now_o !== e.rate) begin
            $display("%0t: rate exp %h got %h", $time, e.rate, rate_now_o);
            errors++;
          end
          if (heading_uncertainty_o !== e.sigma) begin
            $display("%0t: sigma exp %h got %h", $time, e.sigma, heading_uncertainty_o);
            errors++;
          end
          if (singular_o !== e.singular) begin
            $display("%0t: singular exp %b got %b", $time, e.singular, singular_o);
            errors++;
          end
        end
        n_got++;
      end
      if (n_got == 300 && hold_cnt < 3000) begin
        hold_cnt++;
        out_stall_i <= 1'b1;
      end else if (n_got >= 400 && n_got < 520) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 35);
      end
    end
  end

  task automatic wait_idle();
    while (pend_q.size() != 0 || in_valid_i || est_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_noise(logic [30:0] qh, logic [30:0] qr, logic [30:0] rh, logic [30:0] rv);
    logic [30:0] v [4];
    v = '{qh, qr, rh, rv};
    for (int i = 0; i < 4; i++) begin
      @(posedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_addr_i <= 2'(i);
      cfg_wdata_i <= v[i];
      noise[i] = v[i];
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    hd = 0;
    rt = 0;
    cov = '{FXONE, 0, 0, FXONE};
    noise = '{167772, 1677722, 1677722, 3355443};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes at reset noise
    pend_q.push_back(mk_meas(MODE_PREDICT, 25'd0, 0, 0, 0));
    pend_q.push_back(mk_meas(MODE_HRUPD, 0, 32'sh0100_0000, 32'sh7FFF_FFFF, 0));
    pend_q.push_back(mk_meas(MODE_PREDICT, 25'h100_0000, 0, 0, 0));
    pend_q.push_back(mk_meas(MODE_PREDICT, 25'h1FF_FFFF, 0, 0, 0));
    pend_q.push_back(mk_meas(MODE_HUPD, 0, 32'sh7FFF_FFFF, 0, 0));
    pend_q.push_back(mk_meas(MODE_HUPD, 0, 32'sh8000_0000, 0, 0));
    pend_q.push_back(mk_meas(MODE_HRUPD, 0, 32'sh8000_0000, 32'sh8000_0000, 0));
    pend_q.push_back(mk_meas(MODE_REINIT, 0, 0, 0, 27'sh3FF_FFFF));
    pend_q.push_back(mk_meas(MODE_REINIT, 0, 0, 0, 27'sh400_0000));
    pend_q.push_back(mk_meas(MODE_REINIT, 0, 0, 0, 27'(FXPI)));
    pend_q.push_back(mk_meas(MODE_REINIT, 0, 0, 0, 27'(-FXPI)));
    pend_q.push_back(mk_meas(MODE_REINIT, 0, 0, 0, 27'(FXPI + 1)));
    pend_q.push_back(mk_meas(MODE_HRUPD, 0, 32'sh0300_0000, 32'sh0100_0000, 0));
    pend_q.push_back(mk_meas(MODE_PREDICT, 25'h080_0000, 0, 0, 0));
    wait_idle();

    // zero measurement noise: collapse the covariance, then hit zero divisors
    set_noise(31'd0, 31'd0, 31'd0, 31'd0);
    pend_q.push_back(mk_meas(MODE_REINIT, 0, 0, 0, 27'sh10_0000));
    pend_q.push_back(mk_meas(MODE_HUPD, 0, 32'sh0080_0000, 0, 0));
    pend_q.push_back(mk_meas(MODE_HUPD, 0, 32'sh0200_0000, 0, 0));
    pend_q.push_back(mk_meas(MODE_REINIT, 0, 0, 0, 0));
    pend_q.push_back(mk_meas(MODE_HRUPD, 0, 32'sh0040_0000, 32'sh0020_0000, 0));
    pend_q.push_back(mk_meas(MODE_HRUPD, 0, 32'sh0100_0000, 32'sh0100_0000, 0));
    pend_q.push_back(mk_meas(MODE_PREDICT, 25'h100_0000, 0, 0, 0));
    wait_idle();

    // random phases under varying noise, the extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_noise(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        1: set_noise(31'd167772, 31'd1677722, 31'd1677722, 31'd3355443);
        2: set_noise(31'd0, 31'd0, 31'd1, 31'd1);
        default: set_noise(31'($urandom_range(0, 1 << 25)), 31'($urandom_range(0, 1 << 25)),
                           31'($urandom), 31'($urandom_range(0, 1 << 25)));
      endcase
      for (int i = 0; i < 150; i++) pend_q.push_back(rand_meas());
      wait_idle();
    end

    repeat (600) @(posedge clk_i);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #40ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/hkf_pkg.sv
sv/hkf_mul.sv
sv/hkf_div.sv
sv/hkf_wrap.sv
sv/hkf_sqrt.sv
sv/heading_kalman_filter.sv
dv/tb_heading_kalman_filter.sv
